// File: rtl/core/rrmu_pkg.sv
package rrmu_pkg;

  // Field widths of identities and counters.
  localparam int ID_BITS      = 16;
  localparam int DEPTH_BITS   = 16;
  localparam int WAITER_BITS  = 16;
  localparam int CFG_DATA_BITS = 2;

  typedef enum logic [2:0] {
    OP_LOCK        = 3'd0,
    OP_TRYLOCK     = 3'd1,
    OP_UNLOCK      = 3'd2,
    OP_CONSISTENT  = 3'd3,
    OP_WAIT_DONE   = 3'd4,
    OP_THREAD_EXIT = 3'd5,
    OP_DESTROY     = 3'd6,
    OP_INIT        = 3'd7
  } op_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_WAIT      = 4'd1,
    ST_BUSY      = 4'd2,
    ST_DEADLK    = 4'd3,
    ST_PERM      = 4'd4,
    ST_OWNERDEAD = 4'd5,
    ST_NOTREC    = 4'd6,
    ST_INVAL     = 4'd7,
    ST_AGAIN     = 4'd8
  } status_t;

  typedef enum logic [1:0] {
    RS_CONSISTENT      = 2'd0,
    RS_OWNER_DEAD      = 2'd1,
    RS_NOT_RECOVERABLE = 2'd2
  } robust_t;

  // Mutex type codes; the unused code behaves as normal on lock but checks ownership on unlock.
  localparam logic [1:0] MT_NORMAL    = 2'd0;
  localparam logic [1:0] MT_ERRCHK    = 2'd1;
  localparam logic [1:0] MT_RECURSIVE = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MUTEX_TYPE    = 1'b0;
  localparam logic REG_ROBUST_ENABLE = 1'b1;

  typedef struct packed {
    logic [1:0] mutex_type;
    logic       robust_enable;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [ID_BITS-1:0] thread_id;
    logic [ID_BITS-1:0] process_id;
  } req_t;

  typedef struct packed {
    status_t status;
    logic    wake_one;
  } result_t;

  typedef struct packed {
    logic                   owner_valid;
    logic [ID_BITS-1:0]     owner_thread;
    logic [ID_BITS-1:0]     owner_process;
    logic                   owner_exited;
    logic [DEPTH_BITS-1:0]  hold_depth;
    logic [WAITER_BITS-1:0] waiter_count;
    robust_t                robust_status;
    logic                   destroyed;
  } state_t;

endpackage

// File: rtl/core/rrmu_if.sv
interface rrmu_req_if;
  import rrmu_pkg::*;

  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [ID_BITS-1:0] thread_id;
  logic [ID_BITS-1:0] process_id;

  modport source (output valid, output op, output thread_id, output process_id, input ready);
  modport sink   (input valid, input op, input thread_id, input process_id, output ready);
endinterface

interface rrmu_rsp_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic       wake_one;

  modport source (output valid, output status, output wake_one, input ready);
  modport sink   (input valid, input status, input wake_one, output ready);
endinterface

// File: rtl/core/rrmu_decide.sv
module rrmu_decide (
  input  rrmu_pkg::req_t    req,
  input  rrmu_pkg::state_t  cur,
  input  rrmu_pkg::cfg_t    cfg,
  output rrmu_pkg::state_t  nxt,
  output rrmu_pkg::result_t res
);
  import rrmu_pkg::*;

  logic robust;
  logic is_owner;
  logic trylock_req;

  assign robust      = cfg.robust_enable;
  assign is_owner    = cur.owner_valid && (cur.owner_thread == req.thread_id) &&
                       (cur.owner_process == req.process_id);
  assign trylock_req = (req.op == OP_TRYLOCK);

  always_comb begin
    nxt          = cur;
    res.status   = ST_OK;
    res.wake_one = 1'b0;

    if (req.op == OP_INIT) begin
      nxt = '0;
    end else if (cur.destroyed) begin
      res.status = ST_INVAL;
    end else begin
      case (req.op)
        OP_LOCK, OP_TRYLOCK: begin
          if (robust && cur.owner_valid && (cur.owner_process == req.process_id) &&
              cur.owner_exited) begin
            // The owner died: a thread of the same process takes over.
            nxt.owner_valid   = 1'b1;
            nxt.owner_thread  = req.thread_id;
            nxt.owner_process = req.process_id;
            nxt.owner_exited  = 1'b0;
            nxt.hold_depth    = DEPTH_BITS'(1);
            nxt.robust_status = RS_OWNER_DEAD;
            res.status        = ST_OWNERDEAD;
          end else if (!cur.owner_valid) begin
            if (robust && (cur.robust_status == RS_NOT_RECOVERABLE)) begin
              res.status = ST_NOTREC;
            end else begin
              nxt.owner_valid   = 1'b1;
              nxt.owner_thread  = req.thread_id;
              nxt.owner_process = req.process_id;
              nxt.owner_exited  = 1'b0;
              nxt.hold_depth    = DEPTH_BITS'(1);
              if (robust && (cur.robust_status == RS_OWNER_DEAD)) begin
                res.status = ST_OWNERDEAD;
              end
            end
          end else if (is_owner && (cfg.mutex_type == MT_RECURSIVE)) begin
            if (&cur.hold_depth) begin
              res.status = ST_AGAIN;
            end else begin
              nxt.hold_depth = cur.hold_depth + DEPTH_BITS'(1);
            end
          end else if (trylock_req) begin
            res.status = ST_BUSY;
          end else if (is_owner && (cfg.mutex_type == MT_ERRCHK)) begin
            res.status = ST_DEADLK;
          end else if (&cur.waiter_count) begin
            res.status = ST_AGAIN;
          end else begin
            nxt.waiter_count = cur.waiter_count + WAITER_BITS'(1);
            res.status       = ST_WAIT;
          end
        end
        OP_UNLOCK: begin
          if (!is_owner && ((cfg.mutex_type != MT_NORMAL) || robust)) begin
            res.status = ST_PERM;
          end else if (cur.owner_valid) begin
            if (cur.hold_depth > DEPTH_BITS'(1)) begin
              nxt.hold_depth = cur.hold_depth - DEPTH_BITS'(1);
            end else begin
              if (robust && (cur.robust_status == RS_OWNER_DEAD)) begin
                nxt.robust_status = RS_NOT_RECOVERABLE;
              end
              nxt.owner_valid   = 1'b0;
              nxt.owner_thread  = '0;
              nxt.owner_process = '0;
              nxt.owner_exited  = 1'b0;
              nxt.hold_depth    = '0;
              res.wake_one      = (cur.waiter_count != '0);
            end
          end
        end
        OP_CONSISTENT: begin
          if (robust && is_owner && (cur.robust_status == RS_OWNER_DEAD)) begin
            nxt.robust_status = RS_CONSISTENT;
          end else begin
            res.status = ST_INVAL;
          end
        end
        OP_WAIT_DONE: begin
          if (cur.waiter_count != '0) begin
            nxt.waiter_count = cur.waiter_count - WAITER_BITS'(1);
          end
        end
        OP_THREAD_EXIT: begin
          if (is_owner) begin
            nxt.owner_exited = 1'b1;
            res.wake_one     = robust && (cur.waiter_count != '0);
          end
        end
        default: begin
          // Destroy.
          if (cur.owner_valid || (cur.waiter_count != '0)) begin
            res.status = ST_BUSY;
          end else begin
            nxt.destroyed = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/core/rrmu_lock_state.sv
module rrmu_lock_state (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             commit,
  input  rrmu_pkg::state_t state_nxt,
  output rrmu_pkg::state_t lock_state
);
  import rrmu_pkg::*;

  state_t state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (commit) begin
      state_r <= state_nxt;
    end
  end

  assign lock_state = state_r;

endmodule

// File: rtl/core/robust_recursive_mutex_unit.sv
// Channel   Direction  Contents
// in_ch     sink       op, thread_id, process_id
// out_ch    source     status, wake_one
// cfg_*     write      cfg_we, cfg_index, cfg_data (mutex_type, robust_enable)
//
// One transaction is accepted every cycle while in_ch.ready is high; its result passes from the
// input register through the decision stage into the output register when that is free, then onto out_ch.
// The rate is set by the single decision stage that reads and updates the lock state.
// Reset is synchronous on rst_n low and clears the lock state, the configuration and both valids.
// A stalled result holds in the output register while one more request waits in the
// input register; in_ch.ready drops only when both are full and out_ch.ready is low.
module robust_recursive_mutex_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  rrmu_req_if.sink                           in_ch,
  rrmu_rsp_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [rrmu_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import rrmu_pkg::*;

  // Configuration registers, to be written only while the unit is idle; the block does not enforce it.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MUTEX_TYPE:    cfg_r.mutex_type    <= cfg_data;
        REG_ROBUST_ENABLE: cfg_r.robust_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register. The pipeline moves forward whenever the output register is free or is
  // being drained in this cycle.
  logic    in_v_r;
  req_t    in_req_r;
  logic    out_v_r;
  result_t out_res_r;
  logic    advance;
  logic    commit;

  assign advance     = !out_v_r || out_ch.ready;
  assign commit      = in_v_r && advance;
  assign in_ch.ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_req_r.op         <= op_t'(in_ch.op);
      in_req_r.thread_id  <= in_ch.thread_id;
      in_req_r.process_id <= in_ch.process_id;
    end
  end

  // Decision stage: the registered request meets the current lock state. The state is
  // updated in the same cycle that the result is captured, so the next request already
  // sees it.
  state_t  lock_state;
  state_t  state_nxt;
  result_t res_nxt;

  rrmu_decide u_decide (
    .req (in_req_r),
    .cur (lock_state),
    .cfg (cfg_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  rrmu_lock_state u_lock_state (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .state_nxt  (state_nxt),
    .lock_state (lock_state)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.status   = out_res_r.status;
  assign out_ch.wake_one = out_res_r.wake_one;

  // A committed request always leaves a result behind in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) commit |=> out_v_r)
    else $error("committed request produced no result");

  // The hold depth is nonzero exactly while the mutex has an owner.
  assert property (@(posedge clk) disable iff (!rst_n)
    lock_state.owner_valid == (lock_state.hold_depth != '0))
    else $error("hold depth disagrees with ownership");

  // Only init brings a destroyed mutex back.
  assert property (@(posedge clk) disable iff (!rst_n)
    lock_state.destroyed && !(commit && (in_req_r.op == OP_INIT)) |=> lock_state.destroyed)
    else $error("destroyed mutex revived without init");

  // A wake is only ever signaled with a successful status.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_res_r.wake_one |-> out_res_r.status == ST_OK)
    else $error("wake raised on a failing request");

endmodule
